[hw/rtl/ctam_pkg.sv]
// ============================================================================
// ctam_pkg
// Shared types, codes and calendar helpers for the cron-style alarm matcher.
// ============================================================================
package ctam_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_W       = 5;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int WDAY_W    = 3;
    localparam int MIN_MASK_W = 60;
    localparam int HD_MASK_W  = 55;
    localparam int MW_MASK_W  = 19;

    localparam logic [YEAR_W-1:0]   EPOCH_YEAR    = 14'd1970;
    localparam logic [YEAR_W-1:0]   YEAR_MAX      = 14'd16383;
    localparam logic [6:0]          EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]          EPOCH_MOD400  = 9'd370;
    localparam logic [WDAY_W-1:0]   EPOCH_WDAY    = 3'd4;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST   = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_LAST    = 4'd12;
    localparam logic [DAY_W-1:0]    DAY_FIRST     = 5'd1;
    localparam logic [HOUR_W-1:0]   HOUR_LAST     = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST   = 6'd59;

    typedef enum logic [1:0] {
        FUNC_SET  = 2'd0,
        FUNC_MASK = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SEL_MINUTE = 2'd0,
        SEL_HOUR_DAY = 2'd1,
        SEL_MONTH_WEEK = 2'd2,
        SEL_NONE = 2'd3
    } mask_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_SCAN,
        ST_FINISH
    } state_t;

    function automatic logic is_leap(input logic [1:0] y_lo, input logic [6:0] m100,
                                     input logic [8:0] m400);
        is_leap = (m400 == 9'd0) || ((y_lo == 2'd0) && (m100 != 7'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        case (m) inside
            4'd2:                      month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

    function automatic logic [WDAY_W-1:0] mod7(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        for (int i = 0; i < 5; i++) begin
            if (r >= 6'd7) begin
                r = r - 6'd7;
            end
        end
        mod7 = r[WDAY_W-1:0];
    endfunction

endpackage

[hw/rtl/calendar_tick_alarm_matcher_core.sv]
// ============================================================================
// calendar_tick_alarm_matcher_core
// Minute calendar clock with a cron-style match table and first-hit scan.
// ============================================================================
//  channel   dir  handshake                    content
//  s_axis    in   tvalid/tready                tuser: func, mask_select; tdata: fields
//  m_axis    out  tvalid/tready                tuser: matched; tdata: hit, time
//  cfg       in   cfg_we                       cfg_wdata: active_entries
//
//  Tick: the scan reads one table row per cycle. Set time: one year or month
//  per cycle through the shared mod-7 weekday adder.
//  Reset clears clock, table valid bits and config; no clearing pass.
//  A finished result waits in the output register; s_axis is ready in idle.
module calendar_tick_alarm_matcher_core #(
    parameter int MAX_ENTRIES = ctam_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] entry_index, [67:4] mask_value, [81:68] set_year, [85:82] set_month,
    // [90:86] set_day, [95:91] set_hour, [101:96] set_minute
    input  logic [ctam_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] func, [3:2] mask_select
    input  logic [ctam_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [3:0] hit_entry, [17:4] cur_year, [21:18] cur_month, [26:22] cur_day,
    // [31:27] cur_hour, [37:32] cur_minute, [40:38] cur_weekday
    output logic [ctam_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] matched
    output logic                                m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [ctam_pkg::CFG_W-1:0]          cfg_wdata
);
    import ctam_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // input fields
    logic [1:0]            in_func;
    logic [1:0]            in_sel;
    logic [3:0]            in_entry;
    logic [63:0]           in_mask;
    logic [YEAR_W-1:0]     in_year;
    logic [MONTH_W-1:0]    in_month;
    logic [DAY_W-1:0]      in_day;
    logic [HOUR_W-1:0]     in_hour;
    logic [MINUTE_W-1:0]   in_minute;

    assign in_func   = s_axis_tuser[1:0];
    assign in_sel    = s_axis_tuser[3:2];
    assign in_entry  = s_axis_tdata[3:0];
    assign in_mask   = s_axis_tdata[67:4];
    assign in_year   = s_axis_tdata[81:68];
    assign in_month  = s_axis_tdata[85:82];
    assign in_day    = s_axis_tdata[90:86];
    assign in_hour   = s_axis_tdata[95:91];
    assign in_minute = s_axis_tdata[101:96];

    state_t                state_reg, state_next;
    logic [1:0]            func_reg, func_next;
    logic [CFG_W-1:0]      active_entries_reg, active_entries_next;

    logic [YEAR_W-1:0]     clock_year_reg, clock_year_next;
    logic [MONTH_W-1:0]    clock_month_reg, clock_month_next;
    logic [DAY_W-1:0]      clock_day_reg, clock_day_next;
    logic [HOUR_W-1:0]     clock_hour_reg, clock_hour_next;
    logic [MINUTE_W-1:0]   clock_minute_reg, clock_minute_next;
    logic [WDAY_W-1:0]     clock_weekday_reg, clock_weekday_next;
    logic [6:0]            clock_mod100_reg, clock_mod100_next;
    logic [8:0]            clock_mod400_reg, clock_mod400_next;

    logic [YEAR_W-1:0]     walk_year_reg, walk_year_next;
    logic [6:0]            walk_mod100_reg, walk_mod100_next;
    logic [8:0]            walk_mod400_reg, walk_mod400_next;
    logic [MONTH_W-1:0]    walk_month_reg, walk_month_next;
    logic [WDAY_W-1:0]     walk_wday_reg, walk_wday_next;

    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                  res_match_reg, res_match_next;
    logic [IDX_W-1:0]      res_hit_reg, res_hit_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                  m_user_reg, m_user_next;

    logic [MAX_ENTRIES-1:0] min_vld_reg, min_vld_next;
    logic [MAX_ENTRIES-1:0] hd_vld_reg, hd_vld_next;
    logic [MAX_ENTRIES-1:0] mw_vld_reg, mw_vld_next;

    // table memories
    logic [MIN_MASK_W-1:0] min_mem [MAX_ENTRIES];
    logic [HD_MASK_W-1:0]  hd_mem  [MAX_ENTRIES];
    logic [MW_MASK_W-1:0]  mw_mem  [MAX_ENTRIES];
    logic [MIN_MASK_W-1:0] min_rd_reg;
    logic [HD_MASK_W-1:0]  hd_rd_reg;
    logic [MW_MASK_W-1:0]  mw_rd_reg;
    logic                  min_rv_reg, hd_rv_reg, mw_rv_reg;

    logic                  in_xfer;
    logic                  entry_ok;
    logic [IDX_W-1:0]      wr_addr;
    logic                  min_we, hd_we, mw_we;
    logic [IDX_W-1:0]      rd_addr;
    logic [CMP_W-1:0]      n_lim;
    logic                  entry_hit;
    logic                  out_free;

    // shared mod-7 weekday adder
    logic [WDAY_W-1:0]     add_a;
    logic [5:0]            add_b;
    logic [WDAY_W-1:0]     add_sum;

    logic                  walk_leap, clock_leap;
    logic [DAY_W-1:0]      walk_mlen, clock_mlen;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign entry_ok = CMP_W'(in_entry) < CMP_W'(MAX_ENTRIES);
    assign wr_addr  = IDX_W'(in_entry);
    assign min_we   = in_xfer && (in_func == FUNC_MASK) && entry_ok && (in_sel == SEL_MINUTE);
    assign hd_we    = in_xfer && (in_func == FUNC_MASK) && entry_ok && (in_sel == SEL_HOUR_DAY);
    assign mw_we    = in_xfer && (in_func == FUNC_MASK) && entry_ok && (in_sel == SEL_MONTH_WEEK);
    assign rd_addr  = scan_reg[IDX_W-1:0];
    assign n_lim    = (CMP_W'(active_entries_reg) > CMP_W'(MAX_ENTRIES))
                      ? CMP_W'(MAX_ENTRIES) : CMP_W'(active_entries_reg);
    assign out_free = !m_valid_reg || m_axis_tready;

    assign walk_leap  = is_leap(walk_year_reg[1:0], walk_mod100_reg, walk_mod400_reg);
    assign clock_leap = is_leap(clock_year_reg[1:0], clock_mod100_reg, clock_mod400_reg);
    assign walk_mlen  = month_len(walk_month_reg, walk_leap);
    assign clock_mlen = month_len(clock_month_reg, clock_leap);

    assign entry_hit = min_rv_reg && hd_rv_reg && mw_rv_reg
                    && min_rd_reg[clock_minute_reg]
                    && hd_rd_reg[6'(clock_hour_reg)]
                    && hd_rd_reg[6'(clock_day_reg) + 6'd23]
                    && mw_rd_reg[5'(clock_month_reg - MONTH_FIRST)]
                    && mw_rd_reg[5'(clock_weekday_reg) + 5'd12];

    always_comb
    begin
        case (state_reg)
            ST_YEAR:
            begin
                add_a = walk_wday_reg;
                add_b = walk_leap ? 6'd2 : 6'd1;
            end
            ST_MONTH:
            begin
                add_a = walk_wday_reg;
                if (walk_month_reg == clock_month_reg)
                begin
                    add_b = 6'(clock_day_reg - DAY_FIRST);
                end
                else
                begin
                    add_b = 6'(walk_mlen - 5'd28);
                end
            end
            default:
            begin
                add_a = clock_weekday_reg;
                add_b = 6'd1;
            end
        endcase
        add_sum = mod7(6'(add_a) + add_b);
    end

    always_comb
    begin
        state_next          = state_reg;
        func_next           = func_reg;
        active_entries_next = cfg_we ? cfg_wdata : active_entries_reg;
        clock_year_next     = clock_year_reg;
        clock_month_next    = clock_month_reg;
        clock_day_next      = clock_day_reg;
        clock_hour_next     = clock_hour_reg;
        clock_minute_next   = clock_minute_reg;
        clock_weekday_next  = clock_weekday_reg;
        clock_mod100_next   = clock_mod100_reg;
        clock_mod400_next   = clock_mod400_reg;
        walk_year_next      = walk_year_reg;
        walk_mod100_next    = walk_mod100_reg;
        walk_mod400_next    = walk_mod400_reg;
        walk_month_next     = walk_month_reg;
        walk_wday_next      = walk_wday_reg;
        scan_next           = scan_reg;
        chk_valid_next      = chk_valid_reg;
        chk_idx_next        = chk_idx_reg;
        res_match_next      = res_match_reg;
        res_hit_next        = res_hit_reg;
        m_valid_next        = m_valid_reg && !m_axis_tready;
        m_data_next         = m_data_reg;
        m_user_next         = m_user_reg;
        min_vld_next        = min_vld_reg;
        hd_vld_next         = hd_vld_reg;
        mw_vld_next         = mw_vld_reg;
        s_axis_tready       = 1'b0;

        if (min_we)
        begin
            min_vld_next[wr_addr] = 1'b1;
        end
        if (hd_we)
        begin
            hd_vld_next[wr_addr] = 1'b1;
        end
        if (mw_we)
        begin
            mw_vld_next[wr_addr] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    func_next      = in_func;
                    res_match_next = 1'b0;
                    res_hit_next   = '0;
                    case (in_func)
                        FUNC_SET:
                        begin
                            clock_year_next   = (in_year < EPOCH_YEAR) ? EPOCH_YEAR : in_year;
                            clock_month_next  = (in_month < MONTH_FIRST) ? MONTH_FIRST :
                                                (in_month > MONTH_LAST) ? MONTH_LAST : in_month;
                            clock_day_next    = (in_day < DAY_FIRST) ? DAY_FIRST : in_day;
                            clock_hour_next   = (in_hour > HOUR_LAST) ? HOUR_LAST : in_hour;
                            clock_minute_next = (in_minute > MINUTE_LAST) ? MINUTE_LAST
                                                                          : in_minute;
                            walk_year_next    = EPOCH_YEAR;
                            walk_mod100_next  = EPOCH_MOD100;
                            walk_mod400_next  = EPOCH_MOD400;
                            walk_month_next   = MONTH_FIRST;
                            walk_wday_next    = EPOCH_WDAY;
                            state_next        = ST_YEAR;
                        end
                        FUNC_TICK:
                        begin
                            scan_next      = '0;
                            chk_valid_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_YEAR:
            begin
                if (walk_year_reg == clock_year_reg)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    walk_wday_next   = add_sum;
                    walk_year_next   = walk_year_reg + 14'd1;
                    walk_mod100_next = (walk_mod100_reg == 7'd99) ? 7'd0
                                                                  : walk_mod100_reg + 7'd1;
                    walk_mod400_next = (walk_mod400_reg == 9'd399) ? 9'd0
                                                                   : walk_mod400_reg + 9'd1;
                end
            end

            ST_MONTH:
            begin
                if (walk_month_reg == clock_month_reg)
                begin
                    clock_weekday_next = add_sum;
                    clock_mod100_next  = walk_mod100_reg;
                    clock_mod400_next  = walk_mod400_reg;
                    state_next         = ST_FINISH;
                end
                else
                begin
                    walk_wday_next  = add_sum;
                    walk_month_next = walk_month_reg + 4'd1;
                end
            end

            ST_SCAN:
            begin
                if (chk_valid_reg && entry_hit)
                begin
                    res_match_next = 1'b1;
                    res_hit_next   = chk_idx_reg;
                    chk_valid_next = 1'b0;
                    state_next     = ST_FINISH;
                end
                else if (CMP_W'(scan_reg) < n_lim)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_addr;
                    scan_next      = scan_reg + CNT_W'(1);
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_match_reg;
                    m_data_next  = OUT_TDATA_W'({clock_weekday_reg, clock_minute_reg,
                                                 clock_hour_reg, clock_day_reg,
                                                 clock_month_reg, clock_year_reg,
                                                 4'(res_hit_reg)});
                    state_next   = ST_IDLE;
                    if (func_reg == FUNC_TICK)
                    begin
                        // advance one minute
                        if (clock_minute_reg < MINUTE_LAST)
                        begin
                            clock_minute_next = clock_minute_reg + 6'd1;
                        end
                        else
                        begin
                            clock_minute_next = '0;
                            if (clock_hour_reg < HOUR_LAST)
                            begin
                                clock_hour_next = clock_hour_reg + 5'd1;
                            end
                            else
                            begin
                                clock_hour_next    = '0;
                                clock_weekday_next = add_sum;
                                if (clock_day_reg < clock_mlen)
                                begin
                                    clock_day_next = clock_day_reg + 5'd1;
                                end
                                else
                                begin
                                    clock_day_next = DAY_FIRST;
                                    if (clock_month_reg < MONTH_LAST)
                                    begin
                                        clock_month_next = clock_month_reg + 4'd1;
                                    end
                                    else
                                    begin
                                        clock_month_next = MONTH_FIRST;
                                        clock_year_next  = clock_year_reg + 14'd1;
                                        if (clock_year_reg == YEAR_MAX)
                                        begin
                                            clock_mod100_next = '0;
                                            clock_mod400_next = '0;
                                        end
                                        else
                                        begin
                                            clock_mod100_next = (clock_mod100_reg == 7'd99)
                                                ? 7'd0 : clock_mod100_reg + 7'd1;
                                            clock_mod400_next = (clock_mod400_reg == 9'd399)
                                                ? 9'd0 : clock_mod400_reg + 9'd1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            active_entries_reg <= '0;
            clock_year_reg     <= EPOCH_YEAR;
            clock_month_reg    <= MONTH_FIRST;
            clock_day_reg      <= DAY_FIRST;
            clock_hour_reg     <= '0;
            clock_minute_reg   <= '0;
            clock_weekday_reg  <= EPOCH_WDAY;
            clock_mod100_reg   <= EPOCH_MOD100;
            clock_mod400_reg   <= EPOCH_MOD400;
            scan_reg           <= '0;
            chk_valid_reg      <= 1'b0;
            m_valid_reg        <= 1'b0;
            min_vld_reg        <= '0;
            hd_vld_reg         <= '0;
            mw_vld_reg         <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            active_entries_reg <= active_entries_next;
            clock_year_reg     <= clock_year_next;
            clock_month_reg    <= clock_month_next;
            clock_day_reg      <= clock_day_next;
            clock_hour_reg     <= clock_hour_next;
            clock_minute_reg   <= clock_minute_next;
            clock_weekday_reg  <= clock_weekday_next;
            clock_mod100_reg   <= clock_mod100_next;
            clock_mod400_reg   <= clock_mod400_next;
            scan_reg           <= scan_next;
            chk_valid_reg      <= chk_valid_next;
            m_valid_reg        <= m_valid_next;
            min_vld_reg        <= min_vld_next;
            hd_vld_reg         <= hd_vld_next;
            mw_vld_reg         <= mw_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        walk_year_reg   <= walk_year_next;
        walk_mod100_reg <= walk_mod100_next;
        walk_mod400_reg <= walk_mod400_next;
        walk_month_reg  <= walk_month_next;
        walk_wday_reg   <= walk_wday_next;
        chk_idx_reg     <= chk_idx_next;
        res_match_reg   <= res_match_next;
        res_hit_reg     <= res_hit_next;
        m_data_reg      <= m_data_next;
        m_user_reg      <= m_user_next;
        min_rv_reg      <= min_vld_reg[rd_addr];
        hd_rv_reg       <= hd_vld_reg[rd_addr];
        mw_rv_reg       <= mw_vld_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (min_we)
        begin
            min_mem[wr_addr] <= in_mask[MIN_MASK_W-1:0];
        end
        min_rd_reg <= min_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
        begin
            hd_mem[wr_addr] <= in_mask[HD_MASK_W-1:0];
        end
        hd_rd_reg <= hd_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mw_we)
        begin
            mw_mem[wr_addr] <= in_mask[MW_MASK_W-1:0];
        end
        mw_rd_reg <= mw_mem[rd_addr];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_clock_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        clock_minute_reg <= MINUTE_LAST && clock_hour_reg <= HOUR_LAST
        && clock_weekday_reg <= 3'd6 && clock_day_reg != 5'd0
        && clock_month_reg >= MONTH_FIRST && clock_month_reg <= MONTH_LAST)
        else $error("calendar registers out of range");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> CMP_W'(scan_reg) <= n_lim)
        else $error("entry scan ran past the active limit");

    a_no_match_zero_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3:0] == 4'd0)
        else $error("hit entry nonzero without a match");

    a_hit_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && res_match_reg |-> func_reg == FUNC_TICK)
        else $error("match reported for a non-tick transfer");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Streams set-time, mask-write, tick and no-op transfers into the calendar
// alarm matcher and checks every result against a cycle-free model of the
// clock and match table. The run covers several active-entry settings,
// random sender bursts and gaps, receiver stall patterns and one long stall.
// ============================================================================
module testbench;
    import ctam_pkg::*;

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
    localparam int PHASE_ITEMS = 100;
    localparam int LONG_HOLD   = 800;
    localparam int WD_LIMIT    = 60000;

    typedef struct packed {
        func_t                func;
        logic [3:0]           entry;
        mask_sel_t            sel;
        logic [63:0]          mask;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
    } cal_item_t;

    typedef struct packed {
        logic                 matched;
        logic [3:0]           hit;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        logic [WDAY_W-1:0]    wday;
    } cal_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    cal_item_t   pend_q [$];
    cal_result_t expect_q [$];
    int          err_cnt = 0;

    logic [YEAR_W-1:0]     cal_year = EPOCH_YEAR;
    logic [MONTH_W-1:0]    cal_month = MONTH_FIRST;
    logic [DAY_W-1:0]      cal_day = DAY_FIRST;
    logic [HOUR_W-1:0]     cal_hour = '0;
    logic [MINUTE_W-1:0]   cal_minute = '0;
    logic [WDAY_W-1:0]     cal_wday = EPOCH_WDAY;
    logic [MIN_MASK_W-1:0] minute_tbl [TABLE_DEPTH];
    logic [HD_MASK_W-1:0]  hour_day_tbl [TABLE_DEPTH];
    logic [MW_MASK_W-1:0]  month_week_tbl [TABLE_DEPTH];
    logic [CFG_W-1:0]      active_cnt = '0;

    cal_item_t   cur_item;
    bit          sender_busy;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          rx_mode = 0;
    logic [31:0] rx_cycle = '0;
    logic        rdy;
    cal_result_t got;
    cal_result_t want;

    calendar_tick_alarm_matcher_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == 2)
        begin
            return is_leap_year(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11)
        begin
            return 30;
        end
        return 31;
    endfunction

    function automatic int unsigned leaps_upto(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic cal_result_t calendar_step(input cal_item_t it);
        cal_result_t r;
        int unsigned y, m, d, h, mi, days, n;
        r = '0;
        case (it.func)
            FUNC_SET:
            begin
                y  = it.year;
                m  = it.month;
                d  = it.day;
                h  = it.hour;
                mi = it.minute;
                if (y < EPOCH_YEAR) y = EPOCH_YEAR;
                if (m < MONTH_FIRST) m = MONTH_FIRST;
                if (m > MONTH_LAST) m = MONTH_LAST;
                if (d < DAY_FIRST) d = DAY_FIRST;
                if (h > HOUR_LAST) h = HOUR_LAST;
                if (mi > MINUTE_LAST) mi = MINUTE_LAST;
                days = 365 * (y - EPOCH_YEAR) + leaps_upto(y - 1) - leaps_upto(EPOCH_YEAR - 1);
                for (int j = 1; j < m; j++)
                begin
                    days += days_in_month(j, y);
                end
                days += d - 1;
                cal_year   = YEAR_W'(y);
                cal_month  = MONTH_W'(m);
                cal_day    = DAY_W'(d);
                cal_hour   = HOUR_W'(h);
                cal_minute = MINUTE_W'(mi);
                cal_wday   = WDAY_W'((EPOCH_WDAY + days) % 7);
            end
            FUNC_MASK:
            begin
                if (it.entry < TABLE_DEPTH)
                begin
                    case (it.sel)
                        SEL_MINUTE:     minute_tbl[it.entry] = it.mask[MIN_MASK_W-1:0];
                        SEL_HOUR_DAY:   hour_day_tbl[it.entry] = it.mask[HD_MASK_W-1:0];
                        SEL_MONTH_WEEK: month_week_tbl[it.entry] = it.mask[MW_MASK_W-1:0];
                        default:        ;
                    endcase
                end
            end
            default: ;
        endcase
        r.year   = cal_year;
        r.month  = cal_month;
        r.day    = cal_day;
        r.hour   = cal_hour;
        r.minute = cal_minute;
        r.wday   = cal_wday;
        if (it.func == FUNC_TICK)
        begin
            n = (active_cnt > TABLE_DEPTH) ? TABLE_DEPTH : active_cnt;
            for (int e = 0; e < n; e++)
            begin
                if (!r.matched && minute_tbl[e][cal_minute] && hour_day_tbl[e][cal_hour]
                    && hour_day_tbl[e][23 + cal_day] && month_week_tbl[e][cal_month - 1]
                    && month_week_tbl[e][12 + cal_wday])
                begin
                    r.matched = 1'b1;
                    r.hit     = 4'(e);
                end
            end
            if (cal_minute < MINUTE_LAST)
            begin
                cal_minute++;
            end
            else
            begin
                cal_minute = '0;
                if (cal_hour < HOUR_LAST)
                begin
                    cal_hour++;
                end
                else
                begin
                    cal_hour = '0;
                    cal_wday = WDAY_W'((cal_wday + 1) % 7);
                    if (cal_day < days_in_month(cal_month, cal_year))
                    begin
                        cal_day++;
                    end
                    else
                    begin
                        cal_day = DAY_FIRST;
                        if (cal_month < MONTH_LAST)
                        begin
                            cal_month++;
                        end
                        else
                        begin
                            cal_month = MONTH_FIRST;
                            cal_year  = cal_year + 14'd1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic cal_item_t random_item();
        cal_item_t it;
        int unsigned r;
        it.entry  = 4'($urandom_range(0, 15));
        it.sel    = mask_sel_t'($urandom_range(0, 3));
        it.mask   = {$urandom, $urandom};
        it.year   = YEAR_W'($urandom_range(0, 16383));
        it.month  = MONTH_W'($urandom_range(0, 15));
        it.day    = DAY_W'($urandom_range(0, 31));
        it.hour   = HOUR_W'($urandom_range(0, 31));
        it.minute = MINUTE_W'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            it.func = FUNC_TICK;
        end
        else if (r < 80)
        begin
            it.func = FUNC_MASK;
            r = $urandom_range(0, 9);
            if (r < 5)
            begin
                it.mask = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
            end
            else if (r == 5)
            begin
                it.mask = '1;
            end
            if ($urandom_range(0, 9) != 0)
            begin
                it.sel = mask_sel_t'($urandom_range(0, 2));
            end
        end
        else if (r < 93)
        begin
            it.func = FUNC_SET;
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                it.year = YEAR_W'($urandom_range(1960, 2110));
            end
            else if (r < 97)
            begin
                it.year = YEAR_W'($urandom_range(0, 4000));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                it.month = MONTH_LAST;
                it.day   = DAY_W'(31);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                it.hour   = HOUR_LAST;
                it.minute = MINUTE_W'($urandom_range(55, 63));
            end
        end
        else
        begin
            it.func = FUNC_NOP;
        end
        return it;
    endfunction

    function automatic cal_item_t op_item(input func_t f);
        cal_item_t it;
        it      = random_item();
        it.func = f;
        return it;
    endfunction

    function automatic cal_item_t set_item(input int unsigned y, input int unsigned m,
                                           input int unsigned d, input int unsigned h,
                                           input int unsigned mi);
        cal_item_t it;
        it        = op_item(FUNC_SET);
        it.year   = YEAR_W'(y);
        it.month  = MONTH_W'(m);
        it.day    = DAY_W'(d);
        it.hour   = HOUR_W'(h);
        it.minute = MINUTE_W'(mi);
        return it;
    endfunction

    function automatic cal_item_t mask_item(input int unsigned e, input mask_sel_t s,
                                            input logic [63:0] v);
        cal_item_t it;
        it       = op_item(FUNC_MASK);
        it.entry = 4'(e);
        it.sel   = s;
        it.mask  = v;
        return it;
    endfunction

    function automatic void queue_item(input cal_item_t it);
        pend_q.insert(pend_q.size(), it);
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    task automatic write_active(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        active_cnt = v;
        @(posedge clk);
        cfg_we     <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pend_q.size() != 0 || s_axis_tvalid || expect_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expect_q.insert(expect_q.size(), calendar_step(cur_item));
                sender_busy = 1'b0;
            end
            else
            begin
                sender_busy = s_axis_tvalid;
            end
            if (!sender_busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pend_q.size() > 0)
                begin
                    cur_item = pend_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, cur_item.minute, cur_item.hour, cur_item.day,
                                      cur_item.month, cur_item.year, cur_item.mask,
                                      cur_item.entry};
                    s_axis_tuser  <= {cur_item.sel, cur_item.func};
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.matched = m_axis_tuser;
                got.hit     = m_axis_tdata[3:0];
                got.year    = m_axis_tdata[17:4];
                got.month   = m_axis_tdata[21:18];
                got.day     = m_axis_tdata[26:22];
                got.hour    = m_axis_tdata[31:27];
                got.minute  = m_axis_tdata[37:32];
                got.wday    = m_axis_tdata[40:38];
                if (expect_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result: expected none, actual %h", $time, got);
                    err_cnt++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    check_field("matched", want.matched, got.matched);
                    check_field("hit_entry", want.hit, got.hit);
                    check_field("cur_year", want.year, got.year);
                    check_field("cur_month", want.month, got.month);
                    check_field("cur_day", want.day, got.day);
                    check_field("cur_hour", want.hour, got.hour);
                    check_field("cur_minute", want.minute, got.minute);
                    check_field("cur_weekday", want.wday, got.wday);
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (rx_cycle[5:0] == 6'd0)
            begin
                rx_mode = $urandom_range(0, 3);
            end
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = rx_cycle[3];
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WD_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[calendar_tick_alarm_matcher_core] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned cfg_plan [6];
        cfg_plan    = '{31, 3, 0, 16, 1, 0};
        cfg_plan[5] = $urandom_range(0, 31);
        for (int e = 0; e < TABLE_DEPTH; e++)
        begin
            minute_tbl[e]     = '0;
            hour_day_tbl[e]   = '0;
            month_week_tbl[e] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_active(CFG_W'(TABLE_DEPTH));

        queue_item(mask_item(0, SEL_HOUR_DAY, '1));
        queue_item(mask_item(0, SEL_MONTH_WEEK, '1));
        queue_item(mask_item(15, SEL_MINUTE, '1));
        queue_item(mask_item(15, SEL_HOUR_DAY, '1));
        queue_item(mask_item(15, SEL_MONTH_WEEK, '1));
        queue_item(mask_item(1, SEL_NONE, '1));
        queue_item(op_item(FUNC_NOP));
        queue_item(op_item(FUNC_TICK));
        queue_item(mask_item(0, SEL_MINUTE, '1));
        queue_item(op_item(FUNC_TICK));
        queue_item(set_item(16383, 12, 31, 23, 59));
        queue_item(op_item(FUNC_TICK));
        queue_item(op_item(FUNC_TICK));
        queue_item(set_item(0, 0, 0, 31, 63));
        queue_item(op_item(FUNC_TICK));
        queue_item(set_item(2023, 2, 30, 23, 59));
        queue_item(op_item(FUNC_TICK));
        queue_item(set_item(2024, 2, 28, 23, 59));
        queue_item(op_item(FUNC_TICK));
        queue_item(set_item(2100, 2, 28, 23, 59));
        queue_item(op_item(FUNC_TICK));
        queue_item(set_item(2000, 2, 29, 23, 59));
        queue_item(op_item(FUNC_TICK));
        queue_item(set_item(9999, 15, 31, 23, 59));
        queue_item(op_item(FUNC_TICK));
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_active(CFG_W'(cfg_plan[p]));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                queue_item(random_item());
            end
            if (p == 3)
            begin
                hold_req <= 1'b1;
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("[calendar_tick_alarm_matcher_core] OK");
        else
            $display("[calendar_tick_alarm_matcher_core] ERROR");
        $finish;
    end

endmodule
